### design/stt_pkg.sv
// ---------------------------------------------------------------------------
// stt_pkg: shared types for the source text tokenizer
// token kinds and the packed token record passed from scanner to output queue
// ---------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

	localparam int OFFSET_BITS_DEF = 32;
	localparam int OUT_OFF_W       = 32;
	localparam int VALUE_W         = 64;

	typedef enum logic [2:0] {
		KIND_CHAR = 3'd0,
		KIND_INT  = 3'd1,
		KIND_NAME = 3'd2,
		KIND_BIN  = 3'd3,
		KIND_UN   = 3'd4,
		KIND_END  = 3'd5
	} kind_t;

	typedef struct packed {
		kind_t                  kind;
		logic [7:0]             first_char;
		logic [7:0]             second_char;
		logic [VALUE_W-1:0]     int_value;
		logic [OUT_OFF_W-1:0]   start_offset;
		logic [OUT_OFF_W-1:0]   end_offset;
		logic                   last_of_run;
	} token_t;

endpackage

`default_nettype wire

### design/stt_scan.sv
// ---------------------------------------------------------------------------
// stt_scan: scanner state and one-byte step
// holds mode, accumulator, token start, position and pending operator;
// each enabled step consumes one byte and yields zero to two tokens
// ---------------------------------------------------------------------------
`default_nettype none

module stt_scan #(
	parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step_en,
	input  wire logic [7:0]     text_byte,
	output stt_pkg::token_t     tok0,
	output stt_pkg::token_t     tok1,
	output logic [1:0]          tok_cnt
);
	import stt_pkg::*;

	localparam int EXT_W = (OFFSET_BITS > OUT_OFF_W) ? OFFSET_BITS : OUT_OFF_W;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7a;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5a;
	localparam logic [7:0] CH_UNDER = 8'h5f;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_BAR   = 8'h7c;
	localparam logic [7:0] CH_AMP   = 8'h26;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_INT  = 2'd1,
		MODE_NAME = 2'd2,
		MODE_OP   = 2'd3
	} mode_t;

	mode_t                  mode_q, mode_d;
	logic [VALUE_W-1:0]     acc_q, acc_d;
	logic [OFFSET_BITS-1:0] start_q, start_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d;
	logic [7:0]             pend_q, pend_d;

	logic [OFFSET_BITS-1:0] pos_inc;
	logic [VALUE_W-1:0]     acc_x10;
	logic [VALUE_W-1:0]     digit_val;
	logic                   c_digit, c_alpha, c_opstart;
	logic                   consumed;
	logic [1:0]             n_pend;
	token_t                 pend_tok, fresh_tok;
	logic                   fresh_vld;
	logic                   pair_bin, pair_un;

	function automatic logic [OUT_OFF_W-1:0] to_out(input logic [OFFSET_BITS-1:0] v);
		logic [EXT_W-1:0] e;
		e = EXT_W'(v);
		return e[OUT_OFF_W-1:0];
	endfunction

	function automatic token_t mk_tok(input kind_t k, input logic [7:0] a,
			input logic [7:0] b, input logic [VALUE_W-1:0] v,
			input logic [OFFSET_BITS-1:0] s, input logic [OFFSET_BITS-1:0] e);
		token_t t;
		t.kind         = k;
		t.first_char   = a;
		t.second_char  = b;
		t.int_value    = v;
		t.start_offset = to_out(s);
		t.end_offset   = to_out(e);
		t.last_of_run  = 1'b0;
		return t;
	endfunction

	assign pos_inc   = pos_q + OFFSET_BITS'(1);
	assign acc_x10   = {acc_q[VALUE_W-4:0], 3'b000} + {acc_q[VALUE_W-2:0], 1'b0};
	assign digit_val = VALUE_W'(text_byte[3:0]);
	assign c_digit   = text_byte inside {[CH_0:CH_9]};
	assign c_alpha   = (text_byte inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ]})
			|| (text_byte == CH_UNDER);
	assign c_opstart = text_byte inside {CH_PLUS, CH_MINUS, CH_EQ, CH_BAR, CH_AMP, CH_BANG};

	// operator pair against the held first byte
	assign pair_bin = ((pend_q inside {CH_PLUS, CH_MINUS, CH_EQ, CH_BANG})
			&& (text_byte == CH_EQ))
			|| ((pend_q inside {CH_BAR, CH_AMP}) && (text_byte == pend_q));
	assign pair_un  = (pend_q inside {CH_PLUS, CH_MINUS}) && (text_byte == pend_q);

	always_comb begin
		mode_d    = mode_q;
		acc_d     = acc_q;
		start_d   = start_q;
		pend_d    = pend_q;
		pos_d     = pos_inc;
		consumed  = 1'b0;
		n_pend    = 2'd0;
		pend_tok  = '0;
		fresh_tok = '0;
		fresh_vld = 1'b0;

		// close or extend the pending token
		case (mode_q)
			MODE_INT: begin
				if (c_digit) begin
					acc_d    = acc_x10 + digit_val;
					consumed = 1'b1;
				end else begin
					pend_tok = mk_tok(KIND_INT, CH_NUL, CH_NUL, acc_q, start_q, pos_q);
					n_pend   = 2'd1;
				end
			end
			MODE_NAME: begin
				if (c_digit || c_alpha) begin
					consumed = 1'b1;
				end else begin
					pend_tok = mk_tok(KIND_NAME, CH_NUL, CH_NUL, '0, start_q, pos_q);
					n_pend   = 2'd1;
				end
			end
			MODE_OP: begin
				if (pair_bin || pair_un) begin
					pend_tok = mk_tok(pair_bin ? KIND_BIN : KIND_UN, pend_q, text_byte,
							'0, start_q, pos_inc);
					mode_d   = MODE_IDLE;
					consumed = 1'b1;
				end else begin
					pend_tok = mk_tok(KIND_CHAR, pend_q, CH_NUL, '0, start_q, pos_q);
				end
				n_pend = 2'd1;
			end
			default: begin
			end
		endcase

		// scan the byte afresh
		if (!consumed) begin
			mode_d = MODE_IDLE;
			if (text_byte == CH_NUL) begin
				fresh_tok = mk_tok(KIND_END, CH_NUL, CH_NUL, '0, pos_q, pos_q);
				fresh_vld = 1'b1;
				acc_d     = '0;
				pend_d    = '0;
				start_d   = '0;
				pos_d     = '0;
			end else if (c_digit) begin
				mode_d  = MODE_INT;
				acc_d   = digit_val;
				start_d = pos_q;
			end else if (c_alpha) begin
				mode_d  = MODE_NAME;
				start_d = pos_q;
			end else if (c_opstart) begin
				mode_d  = MODE_OP;
				pend_d  = text_byte;
				start_d = pos_q;
			end else begin
				fresh_tok = mk_tok(KIND_CHAR, text_byte, CH_NUL, '0, pos_q, pos_inc);
				fresh_vld = 1'b1;
			end
		end

		// pack into output slots, mark the last one
		tok0 = (n_pend != 2'd0) ? pend_tok : fresh_tok;
		tok1 = fresh_tok;
		if (n_pend != 2'd0 && fresh_vld) begin
			tok_cnt = 2'd2;
			tok1.last_of_run = 1'b1;
		end else if (n_pend != 2'd0 || fresh_vld) begin
			tok_cnt = 2'd1;
			tok0.last_of_run = 1'b1;
		end else begin
			tok_cnt = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			acc_q   <= '0;
			start_q <= '0;
			pos_q   <= '0;
			pend_q  <= '0;
		end else if (step_en) begin
			mode_q  <= mode_d;
			acc_q   <= acc_d;
			start_q <= start_d;
			pos_q   <= pos_d;
			pend_q  <= pend_d;
		end
	end

endmodule

`default_nettype wire

### design/source_text_tokenizer.sv
// ---------------------------------------------------------------------------
// source_text_tokenizer: streaming byte-to-token lexer
// input channel: one source byte per transfer (in_valid/in_ready); a zero
//   byte ends the text, flushes the pending token and gives an end token
// output channel: one token per transfer (out_valid/out_ready) with kind,
//   operator characters, integer value, start/end offsets and last_of_run
// throughput: one byte per cycle while the queue has room; bytes inside
//   a token give no output, a byte that closes a token and is itself a
//   single-char or end token gives two, drained at one per cycle while
//   out_ready is high by the four-entry output queue; a byte is held in
//   the input register and processed only when the queue has room for
//   two tokens, so a stalled receiver backs up into in_ready
// after reset the scanner is idle with offsets at zero and the queue empty
// ---------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer #(
	parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [7:0]                  text_byte,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [2:0]                       token_kind,
	output logic [7:0]                       first_char,
	output logic [7:0]                       second_char,
	output logic [stt_pkg::VALUE_W-1:0]      int_value,
	output logic [stt_pkg::OUT_OFF_W-1:0]    start_offset,
	output logic [stt_pkg::OUT_OFF_W-1:0]    end_offset,
	output logic                             last_of_run
);
	import stt_pkg::*;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// input register
	logic                 byte_vld_s1;
	logic [7:0]           byte_s1;
	logic                 step_en;

	// scanner results
	token_t               tok0, tok1;
	logic [1:0]           tok_cnt;

	// output queue
	token_t               q_mem [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic [Q_CNT_W-1:0]   push_n;
	logic                 pop;
	token_t               head;

	// process the held byte only when two queue slots are sure to be free
	assign step_en  = byte_vld_s1 && (cnt_q <= Q_CNT_W'(Q_DEPTH - 2));
	assign in_ready = !byte_vld_s1 || step_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_vld_s1 <= 1'b0;
		end else if (in_ready) begin
			byte_vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= text_byte;
		end
	end

	stt_scan #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (step_en),
		.text_byte (byte_s1),
		.tok0      (tok0),
		.tok1      (tok1),
		.tok_cnt   (tok_cnt)
	);

	assign push_n = step_en ? Q_CNT_W'(tok_cnt) : '0;
	assign pop    = out_valid && out_ready;

	// queue storage: slot one at the write pointer, slot two just after it
	always_ff @(posedge clk) begin
		if (push_n != '0) begin
			q_mem[wr_ptr_q] <= tok0;
		end
		if (push_n == Q_CNT_W'(2)) begin
			q_mem[wr_ptr_q + Q_PTR_W'(1)] <= tok1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			cnt_q <= cnt_q + push_n - Q_CNT_W'(pop);
		end
	end

	assign head         = q_mem[rd_ptr_q];
	assign out_valid    = (cnt_q != '0);
	assign token_kind   = head.kind;
	assign first_char   = head.first_char;
	assign second_char  = head.second_char;
	assign int_value    = head.int_value;
	assign start_offset = head.start_offset;
	assign end_offset   = head.end_offset;
	assign last_of_run  = head.last_of_run;

	// queue never overfills
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
			cnt_q <= Q_CNT_W'(Q_DEPTH))
		else $error("output queue count beyond depth");

	// a step only runs with room for two tokens
	a_step_room: assert property (@(posedge clk) disable iff (!arst_n)
			step_en |-> (cnt_q <= Q_CNT_W'(Q_DEPTH - 2)))
		else $error("scanner stepped without queue room");

	// an accepted byte sits in the input register next cycle
	a_in_held: assert property (@(posedge clk) disable iff (!arst_n)
			(in_valid && in_ready) |=> byte_vld_s1)
		else $error("accepted byte lost");

	// end token always closes its run
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
			(out_valid && (token_kind == KIND_END)) |-> last_of_run)
		else $error("end token without last_of_run");

endmodule

`default_nettype wire
